FILE: src/uer_pkg.sv
// Package for the ultrasonic echo ranger: item types, phase codes, register map.
`timescale 1ns / 1ps

package uer_pkg;

  localparam int WAIT_W     = 20;
  localparam int TRIG_W     = 8;
  localparam int TIMEOUT_W  = 20;
  localparam int TPU_W      = 10;
  localparam int DIST_OUT_W = 16;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [WAIT_W-1:0]    WAIT_RESET    = 20'd60000;
  localparam logic [TRIG_W-1:0]    TRIG_RESET    = 8'd10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd30000;
  localparam logic [TPU_W-1:0]     TPU_RESET     = 10'd58;

  typedef enum logic [1:0] {
    REG_WAIT    = 2'd0,
    REG_TRIG    = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_TPU     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_TRIG      = 2'd1,
    PH_ECHO_WAIT = 2'd2,
    PH_ECHO_HIGH = 2'd3
  } phase_t;

  typedef struct packed {
    logic enable;
    logic echo_level;
  } in_item_t;

  typedef struct packed {
    logic                  trigger_level;
    logic [DIST_OUT_W-1:0] distance;
    logic                  new_reading;
    logic                  timed_out;
  } out_item_t;

endpackage

FILE: src/ultrasonic_echo_ranger_top.sv
// Ultrasonic echo ranger: trigger/echo sequencer with APB register port.
`timescale 1ns / 1ps

// One input item is one timing tick (enable, sampled echo). Each item yields one
// result item (trigger level, held distance, new_reading and timed_out strobes).
// The whole tick update is one registered pass: an item accepted at a clock edge
// has its result in the output or skid register after that edge, so the block
// takes one item per cycle while in_ready is high. A two-entry output buffer
// (output register plus skid register) lets in_ready stay high while one result
// waits; in_ready drops only when both entries are full. Registers: wait_ticks at
// 0x0, trigger_ticks at 0x4, timeout_ticks at 0x8, ticks_per_unit at 0xC; write
// them only while idle. Distance is floor(echo ticks / ticks_per_unit), capped at
// all ones - 1 and built by a sub-counter; it reads all ones with no reading.
module ultrasonic_echo_ranger_top #(
  parameter int COUNT_WIDTH    = 21,
  parameter int DISTANCE_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  uer_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output uer_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [uer_pkg::DATA_W-1:0] pwdata,
  output logic [uer_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int CMP_W = (COUNT_WIDTH > uer_pkg::WAIT_W) ? COUNT_WIDTH : uer_pkg::WAIT_W;
  localparam logic [COUNT_WIDTH-1:0]    CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [DISTANCE_WIDTH-1:0] DIST_NONE = {DISTANCE_WIDTH{1'b1}};
  localparam logic [DISTANCE_WIDTH-1:0] ACC_MAX = ~DISTANCE_WIDTH'(1);

  // configuration
  logic [uer_pkg::WAIT_W-1:0]    wait_ticks_r;
  logic [uer_pkg::TRIG_W-1:0]    trigger_ticks_r;
  logic [uer_pkg::TIMEOUT_W-1:0] timeout_ticks_r;
  logic [uer_pkg::TPU_W-1:0]     ticks_per_unit_r;
  uer_pkg::reg_idx_t             reg_sel;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = uer_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks_r     <= uer_pkg::WAIT_RESET;
      trigger_ticks_r  <= uer_pkg::TRIG_RESET;
      timeout_ticks_r  <= uer_pkg::TIMEOUT_RESET;
      ticks_per_unit_r <= uer_pkg::TPU_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        uer_pkg::REG_WAIT:    wait_ticks_r     <= pwdata[uer_pkg::WAIT_W-1:0];
        uer_pkg::REG_TRIG:    trigger_ticks_r  <= pwdata[uer_pkg::TRIG_W-1:0];
        uer_pkg::REG_TIMEOUT: timeout_ticks_r  <= pwdata[uer_pkg::TIMEOUT_W-1:0];
        uer_pkg::REG_TPU:     ticks_per_unit_r <= pwdata[uer_pkg::TPU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      uer_pkg::REG_WAIT:    prdata = uer_pkg::DATA_W'(wait_ticks_r);
      uer_pkg::REG_TRIG:    prdata = uer_pkg::DATA_W'(trigger_ticks_r);
      uer_pkg::REG_TIMEOUT: prdata = uer_pkg::DATA_W'(timeout_ticks_r);
      uer_pkg::REG_TPU:     prdata = uer_pkg::DATA_W'(ticks_per_unit_r);
      default:              prdata = '0;
    endcase
  end

  // ranging state
  uer_pkg::phase_t            phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]     elapsed_r, elapsed_nxt, elapsed_inc;
  logic [uer_pkg::TPU_W-1:0]  subcount_r, subcount_nxt;
  logic [DISTANCE_WIDTH-1:0]  acc_r, acc_nxt;
  logic [DISTANCE_WIDTH-1:0]  held_r, held_nxt;
  logic [uer_pkg::TPU_W:0]    sub_inc;
  logic                       unit_done;
  logic [DISTANCE_WIDTH-1:0]  acc_sat_inc;
  logic [CMP_W-1:0]           el_cmp;
  logic                       push;
  uer_pkg::out_item_t         res;

  assign push        = in_valid && in_ready;
  assign elapsed_inc = (elapsed_r != CNT_MAX) ? elapsed_r + 1'b1 : elapsed_r;
  assign el_cmp      = CMP_W'(elapsed_inc);
  // ticks_per_unit of zero behaves as one: the compare is always true
  assign sub_inc     = {1'b0, subcount_r} + 1'b1;
  assign unit_done   = sub_inc >= {1'b0, ticks_per_unit_r};
  assign acc_sat_inc = (acc_r < ACC_MAX) ? acc_r + 1'b1 : acc_r;

  always_comb begin
    phase_nxt         = phase_r;
    elapsed_nxt       = elapsed_r;
    subcount_nxt      = subcount_r;
    acc_nxt           = acc_r;
    held_nxt          = held_r;
    res.trigger_level = 1'b0;
    res.new_reading   = 1'b0;
    res.timed_out     = 1'b0;
    if (!in_data.enable) begin
      elapsed_nxt  = (phase_r != uer_pkg::PH_IDLE) ? '0 : elapsed_inc;
      phase_nxt    = uer_pkg::PH_IDLE;
      subcount_nxt = '0;
      acc_nxt      = '0;
      held_nxt     = DIST_NONE;
    end else begin
      unique case (phase_r)
        uer_pkg::PH_IDLE: begin
          elapsed_nxt = elapsed_inc;
          if (el_cmp > CMP_W'(wait_ticks_r)) begin
            phase_nxt   = uer_pkg::PH_TRIG;
            elapsed_nxt = '0;
          end
        end
        uer_pkg::PH_TRIG: begin
          res.trigger_level = 1'b1;
          elapsed_nxt       = elapsed_inc;
          if (el_cmp >= CMP_W'(trigger_ticks_r)) begin
            phase_nxt   = uer_pkg::PH_ECHO_WAIT;
            elapsed_nxt = '0;
          end
        end
        uer_pkg::PH_ECHO_WAIT: begin
          if (in_data.echo_level) begin
            // first high tick counts from a cleared quotient
            phase_nxt    = uer_pkg::PH_ECHO_HIGH;
            elapsed_nxt  = '0;
            subcount_nxt = (ticks_per_unit_r <= uer_pkg::TPU_W'(1)) ? '0 : uer_pkg::TPU_W'(1);
            acc_nxt      = (ticks_per_unit_r <= uer_pkg::TPU_W'(1)) ?
                           DISTANCE_WIDTH'(1) : '0;
          end else begin
            elapsed_nxt = elapsed_inc;
            if (el_cmp > CMP_W'(timeout_ticks_r)) begin
              res.timed_out = 1'b1;
              phase_nxt     = uer_pkg::PH_IDLE;
              elapsed_nxt   = '0;
            end
          end
        end
        uer_pkg::PH_ECHO_HIGH: begin
          if (in_data.echo_level) begin
            if (unit_done) begin
              subcount_nxt = '0;
              acc_nxt      = acc_sat_inc;
            end else begin
              subcount_nxt = sub_inc[uer_pkg::TPU_W-1:0];
            end
          end else begin
            held_nxt        = acc_r;
            res.new_reading = 1'b1;
            phase_nxt       = uer_pkg::PH_IDLE;
            elapsed_nxt     = '0;
            subcount_nxt    = '0;
            acc_nxt         = '0;
          end
        end
        default: phase_nxt = uer_pkg::PH_IDLE;
      endcase
    end
    res.distance = uer_pkg::DIST_OUT_W'(held_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= uer_pkg::PH_IDLE;
      elapsed_r  <= '0;
      subcount_r <= '0;
      acc_r      <= '0;
      held_r     <= DIST_NONE;
    end else if (push) begin
      phase_r    <= phase_nxt;
      elapsed_r  <= elapsed_nxt;
      subcount_r <= subcount_nxt;
      acc_r      <= acc_nxt;
      held_r     <= held_nxt;
    end
  end

  // two-entry output buffer
  uer_pkg::out_item_t out_r, skid_r;
  logic               out_valid_r, skid_valid_r;
  logic               pop;

  assign pop       = out_valid_r && out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

endmodule

FILE: sim/tb_top.sv
// Testbench for the ultrasonic echo ranger: tick stimulus, predicted readouts, APB setup.
`timescale 1ns / 1ps

module tb_top;

  localparam int COUNT_W    = 21;
  localparam int HOLD_LEN   = 400;
  localparam int MAX_SHOWN  = 40;

  typedef struct packed {
    uer_pkg::phase_t                phase;
    logic [COUNT_W-1:0]             elapsed;
    logic [uer_pkg::TPU_W-1:0]      subcount;
    logic [uer_pkg::DIST_OUT_W-1:0] acc;
    logic [uer_pkg::DIST_OUT_W-1:0] held;
  } ranger_state_t;

  typedef struct packed {
    logic [uer_pkg::WAIT_W-1:0]    wait_ticks;
    logic [uer_pkg::TRIG_W-1:0]    trigger_ticks;
    logic [uer_pkg::TIMEOUT_W-1:0] timeout_ticks;
    logic [uer_pkg::TPU_W-1:0]     ticks_per_unit;
  } ranger_cfg_t;

  typedef struct packed {
    ranger_state_t      st;
    uer_pkg::out_item_t res;
  } tick_step_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  uer_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  uer_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [uer_pkg::ADDR_W-1:0] paddr = '0;
  logic [uer_pkg::DATA_W-1:0] pwdata = '0;
  logic [uer_pkg::DATA_W-1:0] prdata;
  logic pready;

  ranger_cfg_t cfg = '{uer_pkg::WAIT_RESET, uer_pkg::TRIG_RESET,
                       uer_pkg::TIMEOUT_RESET, uer_pkg::TPU_RESET};
  ranger_state_t gen_st;
  ranger_state_t chk_st;

  uer_pkg::in_item_t  echo_tick_q[$];
  uer_pkg::out_item_t ranger_out_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit in_took = 1'b0;

  int n_fail = 0;
  int n_ticks = 0;
  int n_readings = 0;
  int n_timeouts = 0;
  int n_in_stall = 0;
  int n_settings = 0;
  int max_distance = 0;

  ultrasonic_echo_ranger_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic ranger_state_t idle_state();
    ranger_state_t s;
    s.phase    = uer_pkg::PH_IDLE;
    s.elapsed  = '0;
    s.subcount = '0;
    s.acc      = '0;
    s.held     = '1;
    return s;
  endfunction

  // One high echo tick: sub-counter rolls over into the quotient, which stops at all ones - 1.
  function automatic ranger_state_t add_echo_tick(ranger_state_t s);
    s.subcount = s.subcount + 1'b1;
    if (s.subcount >= cfg.ticks_per_unit) begin
      s.subcount = '0;
      if (s.acc < {{(uer_pkg::DIST_OUT_W-1){1'b1}}, 1'b0}) s.acc = s.acc + 1'b1;
    end
    return s;
  endfunction

  function automatic tick_step_t range_tick(ranger_state_t s, uer_pkg::in_item_t it);
    tick_step_t r;
    r.res = '0;
    if (!it.enable) begin
      if (s.phase != uer_pkg::PH_IDLE) s.elapsed = '0;
      else if (s.elapsed != '1) s.elapsed = s.elapsed + 1'b1;
      s.phase    = uer_pkg::PH_IDLE;
      s.subcount = '0;
      s.acc      = '0;
      s.held     = '1;
    end else begin
      case (s.phase)
        uer_pkg::PH_IDLE: begin
          if (s.elapsed != '1) s.elapsed = s.elapsed + 1'b1;
          if (s.elapsed > cfg.wait_ticks) begin
            s.phase   = uer_pkg::PH_TRIG;
            s.elapsed = '0;
          end
        end
        uer_pkg::PH_TRIG: begin
          r.res.trigger_level = 1'b1;
          if (s.elapsed != '1) s.elapsed = s.elapsed + 1'b1;
          if (s.elapsed >= cfg.trigger_ticks) begin
            s.phase   = uer_pkg::PH_ECHO_WAIT;
            s.elapsed = '0;
          end
        end
        uer_pkg::PH_ECHO_WAIT: begin
          if (it.echo_level) begin
            s.phase    = uer_pkg::PH_ECHO_HIGH;
            s.elapsed  = '0;
            s.subcount = '0;
            s.acc      = '0;
            s = add_echo_tick(s);
          end else begin
            if (s.elapsed != '1) s.elapsed = s.elapsed + 1'b1;
            if (s.elapsed > cfg.timeout_ticks) begin
              r.res.timed_out = 1'b1;
              s.phase   = uer_pkg::PH_IDLE;
              s.elapsed = '0;
            end
          end
        end
        uer_pkg::PH_ECHO_HIGH: begin
          if (it.echo_level) begin
            s = add_echo_tick(s);
          end else begin
            s.held     = s.acc;
            r.res.new_reading = 1'b1;
            s.phase    = uer_pkg::PH_IDLE;
            s.elapsed  = '0;
            s.subcount = '0;
            s.acc      = '0;
          end
        end
      endcase
    end
    r.res.distance = s.held;
    r.st = s;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    n_fail++;
    if (n_fail <= MAX_SHOWN) $error("readout mismatch: %s expected %0d, got %0d", field, want, got);
  endtask

  // Sender: new item whenever the slot is free and the idle draw allows it.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (echo_tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= echo_tick_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Predict on each accepted tick, check each accepted readout.
  always @(posedge clk) begin : mon
    tick_step_t         nxt;
    uer_pkg::out_item_t want;
    if (!rst_n) begin
      chk_st  = idle_state();
      in_took = 1'b0;
    end else begin
      in_took = in_valid && in_ready;
      if (in_valid && !in_ready) n_in_stall++;
      if (in_took) begin
        nxt = range_tick(chk_st, in_data);
        chk_st = nxt.st;
        ranger_out_q.push_back(nxt.res);
        n_ticks++;
      end
      if (out_valid && out_ready) begin
        if (ranger_out_q.size() == 0) begin
          n_fail++;
          $error("readout arrived with no tick pending");
        end else begin
          want = ranger_out_q.pop_front();
          if (out_data.trigger_level !== want.trigger_level)
            report_mismatch("trigger_level", want.trigger_level, out_data.trigger_level);
          if (out_data.distance !== want.distance)
            report_mismatch("distance", want.distance, out_data.distance);
          if (out_data.new_reading !== want.new_reading)
            report_mismatch("new_reading", want.new_reading, out_data.new_reading);
          if (out_data.timed_out !== want.timed_out)
            report_mismatch("timed_out", want.timed_out, out_data.timed_out);
          if (want.new_reading) begin
            n_readings++;
            if (want.distance > max_distance) max_distance = want.distance;
          end
          if (want.timed_out) n_timeouts++;
        end
      end
    end
  end

  // APB write then read-back of the same register.
  task automatic write_reg(input uer_pkg::reg_idx_t idx,
                           input logic [uer_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      uer_pkg::REG_WAIT:    cfg.wait_ticks     = value[uer_pkg::WAIT_W-1:0];
      uer_pkg::REG_TRIG:    cfg.trigger_ticks  = value[uer_pkg::TRIG_W-1:0];
      uer_pkg::REG_TIMEOUT: cfg.timeout_ticks  = value[uer_pkg::TIMEOUT_W-1:0];
      uer_pkg::REG_TPU:     cfg.ticks_per_unit = value[uer_pkg::TPU_W-1:0];
    endcase
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      n_fail++;
      $error("register %s read back: expected %0d, got %0d", idx.name(), value, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_ranger(input logic [uer_pkg::DATA_W-1:0] wait_v,
                            input logic [uer_pkg::DATA_W-1:0] trig_v,
                            input logic [uer_pkg::DATA_W-1:0] tout_v,
                            input logic [uer_pkg::DATA_W-1:0] tpu_v);
    write_reg(uer_pkg::REG_WAIT, wait_v);
    write_reg(uer_pkg::REG_TRIG, trig_v);
    write_reg(uer_pkg::REG_TIMEOUT, tout_v);
    write_reg(uer_pkg::REG_TPU, tpu_v);
    n_settings++;
  endtask

  task automatic push_tick(input uer_pkg::in_item_t it);
    tick_step_t nxt;
    nxt = range_tick(gen_st, it);
    gen_st = nxt.st;
    echo_tick_q.push_back(it);
  endtask

  // Mostly well-formed ranging cycles: echo rises after a random wait (sometimes past
  // the timeout) and stays high for a random length; noise adds aborts and glitches.
  task automatic gen_ticks(input int n, input int noise, input int hi_lo, input int hi_hi);
    uer_pkg::in_item_t it;
    uer_pkg::phase_t   was;
    int cnt;
    int target;
    int span;
    cnt = 0;
    target = 0;
    span = (cfg.timeout_ticks > 36) ? 40 : int'(cfg.timeout_ticks) + 4;
    repeat (n) begin
      it.enable = ($urandom_range(0, 999) >= noise);
      case (gen_st.phase)
        uer_pkg::PH_ECHO_WAIT: it.echo_level = (cnt >= target);
        uer_pkg::PH_ECHO_HIGH: it.echo_level = (cnt < target);
        default:               it.echo_level = 1'($urandom_range(0, 1));
      endcase
      if ($urandom_range(0, 999) < 3 * noise) it.echo_level = ~it.echo_level;
      was = gen_st.phase;
      push_tick(it);
      if (gen_st.phase != was) begin
        cnt = 0;
        if (gen_st.phase == uer_pkg::PH_ECHO_WAIT) begin
          target = $urandom_range(0, span);
        end else if (gen_st.phase == uer_pkg::PH_ECHO_HIGH) begin
          cnt = 1;
          target = $urandom_range(hi_lo, hi_hi);
        end
      end else begin
        cnt++;
      end
    end
  endtask

  task automatic settle();
    while (echo_tick_q.size() != 0 || in_valid || ranger_out_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_ticks(input int send_pct, input int recv_pct, input int n,
                           input int noise, input int hi_lo, input int hi_hi);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    gen_ticks(n, noise, hi_lo, hi_hi);
    settle();
  endtask

  task automatic random_settings();
    set_ranger($urandom_range(0, 8), $urandom_range(0, 12), $urandom_range(0, 20),
               $urandom_range(0, 12));
  endtask

  logic [16:0] dir_en   = 17'h12FFE;
  logic [16:0] dir_echo = 17'h198C6;

  initial begin : stim
    uer_pkg::in_item_t it;
    int mode;
    gen_st = idle_state();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all-zero settings give zero trigger_ticks and zero divisor;
    // covers timeout, a reading, abort in echo-high and in trigger, disabled idle.
    set_ranger(0, 0, 0, 0);
    for (int i = 0; i < 17; i++) begin
      it.enable     = dir_en[i];
      it.echo_level = dir_echo[i];
      push_tick(it);
    end
    settle();

    set_ranger(2, 3, 6, 2);
    run_ticks(0, 0, 150, 10, 1, 10);

    random_settings();
    run_ticks(87, 0, 150, 8, 1, 3 * cfg.ticks_per_unit + 4);
    random_settings();
    run_ticks(0, 87, 150, 8, 1, 3 * cfg.ticks_per_unit + 4);
    random_settings();
    run_ticks(12, 12, 150, 8, 1, 3 * cfg.ticks_per_unit + 4);

    // Receiver holds off while the sender keeps offering: output buffer fills.
    random_settings();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    gen_ticks(150, 8, 1, 3 * cfg.ticks_per_unit + 4);
    hold_seq++;
    settle();

    // Extremes of the settings.
    set_ranger(0, 255, 1048575, 1023);
    run_ticks(0, 0, 320, 0, 1, 20);
    set_ranger(1048575, 1, 0, 1);
    run_ticks(12, 12, 100, 8, 1, 6);

    repeat (4) begin
      random_settings();
      mode = $urandom_range(0, 3);
      case (mode)
        0: run_ticks(0, 0, 15, 8, 1, 3 * cfg.ticks_per_unit + 4);
        1: run_ticks(87, 0, 15, 8, 1, 3 * cfg.ticks_per_unit + 4);
        2: run_ticks(0, 87, 15, 8, 1, 3 * cfg.ticks_per_unit + 4);
        default: run_ticks(12, 12, 15, 8, 1, 3 * cfg.ticks_per_unit + 4);
      endcase
    end

    repeat (8) @(posedge clk);
    $display("summary: %0d ticks over %0d register settings, %0d readings (max %0d), %0d timeouts",
             n_ticks, n_settings, n_readings, max_distance, n_timeouts);
    $display("summary: input held back by a full output on %0d cycles", n_in_stall);
    if (n_fail == 0 && ranger_out_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #400_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: ultrasonic_echo_ranger_top.f
src/uer_pkg.sv
src/ultrasonic_echo_ranger_top.sv
sim/tb_top.sv
